>>> hdl/acev_pkg.sv
// Shared types and constants for the axiom core coverage evaluator.
`default_nettype none
package acev_pkg;

    localparam int MAX_SENTENCES_DEF = 1024;
    localparam int KIND_W            = 2;
    localparam int SENT_W            = 10;
    localparam int COUNT_W           = 11;
    localparam logic [COUNT_W-1:0] SENT_COUNT_RST = 11'd1024;

    typedef enum logic [KIND_W-1:0] {
        KIND_START      = 2'd0,
        KIND_PREMISE    = 2'd1,
        KIND_CONCLUSION = 2'd2
    } t_kind;

endpackage
`default_nettype wire

>>> hdl/axiom_core_coverage_eval_unit.sv
// An accepted request is registered into stage one, then into the output registers behind o_valid.
// One request per cycle unless i_ready stalls; the mark memory read and row update are two stages.
// The last row write is forwarded so back-to-back requests on one row stay exact.
// Reset (synchronous, active low) clears counts, flags, pipeline valids and all row valid bits;
// a start request clears the evaluation at once, with no clearing pass.
`default_nettype none
module axiom_core_coverage_eval_unit
    import acev_pkg::*;
#(
    parameter int MAX_SENTENCES = MAX_SENTENCES_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_we,
    input  wire logic [COUNT_W-1:0] i_cfg_wdata,
    input  wire logic               i_valid,
    output logic                    o_ready,
    input  wire logic [KIND_W-1:0]  i_kind,
    input  wire logic [SENT_W-1:0]  i_sentence,
    output logic                    o_valid,
    input  wire logic               i_ready,
    output logic      [COUNT_W-1:0] o_axiom_count,
    output logic      [COUNT_W-1:0] o_covered_count,
    output logic                    o_complete,
    output logic                    o_out_of_range
);

    localparam int IDX_W  = $clog2(MAX_SENTENCES);
    localparam int ROW_LG = (IDX_W < 5) ? IDX_W : ((IDX_W > 13) ? IDX_W - 8 : 5);
    localparam int ROW_W  = 1 << ROW_LG;
    localparam int RA_W   = (IDX_W - ROW_LG < 1) ? 1 : IDX_W - ROW_LG;
    localparam int LIM_W  = ($clog2(MAX_SENTENCES + 1) > COUNT_W) ?
                            $clog2(MAX_SENTENCES + 1) : COUNT_W;

    logic [COUNT_W-1:0] r_cfg;

    logic               r_s1_valid;
    logic [KIND_W-1:0]  r_s1_kind;
    logic [SENT_W-1:0]  r_s1_sent;

    logic               r_fwd_vld;
    logic [RA_W-1:0]    r_fwd_addr;
    logic [ROW_W-1:0]   r_fwd_data;

    logic [COUNT_W-1:0] r_ax;
    logic [COUNT_W-1:0] r_cov;
    logic               r_done;

    logic               r_out_valid;
    logic [COUNT_W-1:0] r_out_ax;
    logic [COUNT_W-1:0] r_out_cov;
    logic               r_out_done;
    logic               r_out_oor;

    logic               accept;
    logic               advance;
    logic               step;
    logic [IDX_W-1:0]   in_idx;
    logic [IDX_W-1:0]   s1_idx;
    logic [RA_W-1:0]    in_ra;
    logic [RA_W-1:0]    s1_ra;
    logic [ROW_LG-1:0]  s1_bit;
    logic [ROW_W-1:0]   rd_data;
    logic               chk_valid;
    logic [ROW_W-1:0]   row;
    logic [ROW_W-1:0]   row_set;
    logic [LIM_W-1:0]   limit;
    logic               is_mark;
    logic               is_start;
    logic               oor;
    logic               live;
    logic               fresh;
    logic               wr_en;
    logic [COUNT_W-1:0] n_ax;
    logic [COUNT_W-1:0] n_cov;
    logic               n_done;

    assign advance = !r_out_valid || i_ready;
    assign step    = r_s1_valid && advance;
    assign o_ready = !r_s1_valid || advance;
    assign accept  = i_valid && o_ready;

    assign in_idx = IDX_W'(i_sentence);
    assign s1_idx = IDX_W'(r_s1_sent);
    assign in_ra  = RA_W'(in_idx >> ROW_LG);
    assign s1_ra  = RA_W'(s1_idx >> ROW_LG);
    assign s1_bit = s1_idx[ROW_LG-1:0];

    acev_mark_mem #(
        .RA_W  (RA_W),
        .ROW_W (ROW_W)
    ) u_marks (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_rd_en     (accept),
        .i_rd_addr   (in_ra),
        .o_rd_data   (rd_data),
        .i_chk_addr  (s1_ra),
        .o_chk_valid (chk_valid),
        .i_wr_en     (wr_en),
        .i_wr_addr   (s1_ra),
        .i_wr_data   (row_set),
        .i_clr       (step && is_start)
    );

    always_comb begin
        if (r_cfg == '0) begin
            limit = LIM_W'(1);
        end else if (LIM_W'(r_cfg) > LIM_W'(MAX_SENTENCES)) begin
            limit = LIM_W'(MAX_SENTENCES);
        end else begin
            limit = LIM_W'(r_cfg);
        end
    end

    always_comb begin
        if (!chk_valid) begin
            row = '0;
        end else if (r_fwd_vld && r_fwd_addr == s1_ra) begin
            row = r_fwd_data;
        end else begin
            row = rd_data;
        end
        row_set         = row;
        row_set[s1_bit] = 1'b1;
    end

    assign is_start = (r_s1_kind == KIND_START);
    assign is_mark  = (r_s1_kind == KIND_PREMISE) || (r_s1_kind == KIND_CONCLUSION);
    assign oor      = is_mark && (LIM_W'(r_s1_sent) >= limit);
    assign live     = is_mark && !oor && !r_done;
    assign fresh    = live && !row[s1_bit];
    assign wr_en    = step && fresh;

    always_comb begin
        n_ax   = r_ax;
        n_cov  = r_cov;
        n_done = r_done;
        if (is_start) begin
            n_ax   = '0;
            n_cov  = '0;
            n_done = 1'b0;
        end else if (live) begin
            if (fresh) begin
                n_cov = r_cov + COUNT_W'(1);
                if (r_s1_kind == KIND_PREMISE) begin
                    n_ax = r_ax + COUNT_W'(1);
                end
            end
            if (LIM_W'(n_cov) >= limit) begin
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= SENT_COUNT_RST;
        end else if (i_cfg_we) begin
            r_cfg <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_fwd_vld   <= 1'b0;
            r_ax        <= '0;
            r_cov       <= '0;
            r_done      <= 1'b0;
        end else begin
            if (accept) begin
                r_s1_valid <= 1'b1;
            end else if (advance) begin
                r_s1_valid <= 1'b0;
            end
            if (step) begin
                r_out_valid <= 1'b1;
                r_ax        <= n_ax;
                r_cov       <= n_cov;
                r_done      <= n_done;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
            if (step && is_start) begin
                r_fwd_vld <= 1'b0;
            end else if (wr_en) begin
                r_fwd_vld <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_kind <= i_kind;
            r_s1_sent <= i_sentence;
        end
        if (wr_en) begin
            r_fwd_addr <= s1_ra;
            r_fwd_data <= row_set;
        end
        if (step) begin
            r_out_ax   <= n_ax;
            r_out_cov  <= n_cov;
            r_out_done <= n_done;
            r_out_oor  <= oor;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_axiom_count   = r_out_ax;
    assign o_covered_count = r_out_cov;
    assign o_complete      = r_out_done;
    assign o_out_of_range  = r_out_oor;

endmodule
`default_nettype wire

>>> hdl/acev_mark_mem.sv
// Row-organized seen-mark memory with per-row valid bits for fast clearing.
`default_nettype none
module acev_mark_mem #(
    parameter int RA_W  = 5,
    parameter int ROW_W = 32
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_rd_en,
    input  wire logic [RA_W-1:0]  i_rd_addr,
    output logic      [ROW_W-1:0] o_rd_data,
    input  wire logic [RA_W-1:0]  i_chk_addr,
    output logic                  o_chk_valid,
    input  wire logic             i_wr_en,
    input  wire logic [RA_W-1:0]  i_wr_addr,
    input  wire logic [ROW_W-1:0] i_wr_data,
    input  wire logic             i_clr
);

    localparam int ROWS = 1 << RA_W;

    logic [ROW_W-1:0] r_mem [ROWS];
    logic [ROW_W-1:0] r_rd_data;
    logic [ROWS-1:0]  r_row_vld;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_vld <= '0;
        end else if (i_clr) begin
            r_row_vld <= '0;
        end else if (i_wr_en) begin
            r_row_vld[i_wr_addr] <= 1'b1;
        end
    end

    assign o_rd_data   = r_rd_data;
    assign o_chk_valid = r_row_vld[i_chk_addr];

endmodule
`default_nettype wire

>>> tb/axiom_core_coverage_eval_unit_test.sv
// Testbench for the axiom core coverage evaluator: queued requests, predictor and checker.
`timescale 1ns / 100ps
module axiom_core_coverage_eval_unit_test;
    import acev_pkg::*;

    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
    localparam int CYCLE_LIMIT = 400000;
    localparam int LONG_HOLD   = 600;

    typedef struct {
        logic [KIND_W-1:0] kind;
        logic [SENT_W-1:0] sentence;
        int unsigned       gap;
    } t_eval_request;

    typedef struct {
        logic [COUNT_W-1:0] axiom_count;
        logic [COUNT_W-1:0] covered_count;
        logic               complete;
        logic               out_of_range;
    } t_coverage_result;

    logic               i_clk;
    logic               i_rst_n     = 1'b0;
    logic               i_cfg_we    = 1'b0;
    logic [COUNT_W-1:0] i_cfg_wdata = '0;
    logic               i_valid     = 1'b0;
    logic               o_ready;
    logic [KIND_W-1:0]  i_kind      = KIND_START;
    logic [SENT_W-1:0]  i_sentence  = '0;
    logic               o_valid;
    logic               i_ready     = 1'b0;
    logic [COUNT_W-1:0] o_axiom_count;
    logic [COUNT_W-1:0] o_covered_count;
    logic               o_complete;
    logic               o_out_of_range;

    axiom_core_coverage_eval_unit dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_kind          (i_kind),
        .i_sentence      (i_sentence),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_axiom_count   (o_axiom_count),
        .o_covered_count (o_covered_count),
        .o_complete      (o_complete),
        .o_out_of_range  (o_out_of_range)
    );

    t_eval_request    pending_reqs[$];
    t_coverage_result expected_scores[$];

    // predictor state
    logic [COUNT_W-1:0] sentence_limit_reg = SENT_COUNT_RST;
    logic               seen_sentence[MAX_SENTENCES_DEF];
    logic [COUNT_W-1:0] axioms_so_far;
    logic [COUNT_W-1:0] covered_so_far;
    logic               eval_complete;

    int          error_count  = 0;
    int unsigned cycle_count  = 0;
    int unsigned drv_wait     = 0;
    int unsigned rcv_wait     = 0;
    int unsigned hold_left    = 0;
    bit          drv_burst    = 0;
    bit          rcv_burst    = 0;
    int          results_seen = 0;
    int          holds_done   = 0;
    int          next_hold_at = 100;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    function automatic int unsigned effective_limit();
        if (sentence_limit_reg == 0)
            return 1;
        if (sentence_limit_reg > MAX_SENTENCES_DEF)
            return MAX_SENTENCES_DEF;
        return sentence_limit_reg;
    endfunction

    task automatic clear_evaluation_model();
        foreach (seen_sentence[i])
            seen_sentence[i] = 1'b0;
        axioms_so_far  = '0;
        covered_so_far = '0;
        eval_complete  = 1'b0;
    endtask

    task automatic score_request(input logic [KIND_W-1:0] kind, input logic [SENT_W-1:0] sent);
        int unsigned      lim;
        t_coverage_result r;
        lim = effective_limit();
        r.out_of_range = 1'b0;
        if (kind == KIND_START) begin
            clear_evaluation_model();
        end else if (kind == KIND_PREMISE || kind == KIND_CONCLUSION) begin
            if (sent >= lim) begin
                r.out_of_range = 1'b1;
            end else if (!eval_complete) begin
                if (!seen_sentence[sent]) begin
                    seen_sentence[sent] = 1'b1;
                    covered_so_far++;
                    if (kind == KIND_PREMISE)
                        axioms_so_far++;
                end
                if (covered_so_far >= lim)
                    eval_complete = 1'b1;
            end
        end
        r.axiom_count   = axioms_so_far;
        r.covered_count = covered_so_far;
        r.complete      = eval_complete;
        expected_scores.push_back(r);
    endtask

    task automatic check_field(input string name, input logic [COUNT_W-1:0] exp_v,
                               input logic [COUNT_W-1:0] act_v);
        if (exp_v !== act_v) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
            error_count++;
        end
    endtask

    // driver
    always @(posedge i_clk) begin : driver
        logic          busy;
        t_eval_request req;
        if (!i_rst_n) begin
            i_valid  <= 1'b0;
            drv_wait <= 0;
        end else begin
            busy = i_valid;
            if (i_valid && o_ready) begin
                score_request(i_kind, i_sentence);
                busy = 1'b0;
            end
            if (!busy) begin
                if (drv_wait != 0) begin
                    drv_wait <= drv_wait - 1;
                    i_valid  <= 1'b0;
                end else if (pending_reqs.size() != 0) begin
                    req = pending_reqs.pop_front();
                    i_valid    <= 1'b1;
                    i_kind     <= req.kind;
                    i_sentence <= req.sentence;
                    drv_wait   <= req.gap;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // monitor and receiver stalls
    always @(posedge i_clk) begin : monitor
        logic             ready_next;
        int unsigned      wait_n;
        t_coverage_result exp_r;
        if (!i_rst_n) begin
            i_ready   <= 1'b0;
            rcv_wait  <= 0;
            hold_left <= 0;
        end else begin
            ready_next = i_ready;
            if (o_valid && i_ready) begin
                results_seen++;
                if (expected_scores.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual axioms %0d covered %0d",
                             $time, o_axiom_count, o_covered_count);
                    error_count++;
                end else begin
                    exp_r = expected_scores.pop_front();
                    check_field("axiom_count", exp_r.axiom_count, o_axiom_count);
                    check_field("covered_count", exp_r.covered_count, o_covered_count);
                    check_field("complete", COUNT_W'(exp_r.complete), COUNT_W'(o_complete));
                    check_field("out_of_range", COUNT_W'(exp_r.out_of_range),
                                COUNT_W'(o_out_of_range));
                end
                if ($urandom_range(0, 39) == 0)
                    rcv_burst = !rcv_burst;
                wait_n = rcv_burst ? 0 : $urandom_range(0, 10);
                if (wait_n != 0)
                    ready_next = 1'b0;
                rcv_wait <= wait_n;
            end else if (!i_ready) begin
                if (hold_left != 0)
                    hold_left <= hold_left - 1;
                else if (rcv_wait != 0)
                    rcv_wait <= rcv_wait - 1;
                else
                    ready_next = 1'b1;
            end
            // long hold-off while the sender still has plenty queued
            if (holds_done < 2 && hold_left == 0 && results_seen >= next_hold_at &&
                pending_reqs.size() > 100) begin
                hold_left <= LONG_HOLD;
                ready_next = 1'b0;
                holds_done++;
                next_hold_at = results_seen + 500;
            end
            i_ready <= ready_next;
        end
    end

    task automatic queue_request(input logic [KIND_W-1:0] kind, input logic [SENT_W-1:0] sent);
        t_eval_request req;
        if ($urandom_range(0, 39) == 0)
            drv_burst = !drv_burst;
        req.kind     = kind;
        req.sentence = sent;
        req.gap      = drv_burst ? 0 : $urandom_range(0, 10);
        pending_reqs.push_back(req);
    endtask

    task automatic wait_idle();
        while (pending_reqs.size() != 0 || i_valid || expected_scores.size() != 0)
            @(negedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic set_sentence_count(input logic [COUNT_W-1:0] value);
        wait_idle();
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        sentence_limit_reg = value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    function automatic logic [SENT_W-1:0] pick_sentence(input int unsigned lim);
        if ($urandom_range(0, 9) == 0)
            return SENT_W'($urandom_range(0, MAX_SENTENCES_DEF - 1));
        return SENT_W'($urandom_range(0, lim - 1));
    endfunction

    // mostly well-formed rule streams, with some noise and restarts
    task automatic gen_eval_stream(input int n);
        int          emitted;
        int          roll;
        int          np;
        int unsigned lim;
        lim = effective_limit();
        queue_request(KIND_START, SENT_W'($urandom_range(0, MAX_SENTENCES_DEF - 1)));
        emitted = 1;
        while (emitted < n) begin
            roll = $urandom_range(0, 99);
            if (roll < 8) begin
                queue_request(KIND_W'($urandom_range(0, 3)),
                              SENT_W'($urandom_range(0, MAX_SENTENCES_DEF - 1)));
                emitted++;
            end else if (roll < 12) begin
                queue_request(KIND_START, SENT_W'($urandom_range(0, MAX_SENTENCES_DEF - 1)));
                emitted++;
            end else begin
                np = $urandom_range(0, 3);
                repeat (np) begin
                    queue_request(KIND_PREMISE, pick_sentence(lim));
                    emitted++;
                end
                queue_request(KIND_CONCLUSION, pick_sentence(lim));
                emitted++;
            end
        end
    endtask

    initial begin : stimulus
        int                 perm[MAX_SENTENCES_DEF];
        int                 j;
        int                 tmp;
        logic [COUNT_W-1:0] phase_counts[11];
        clear_evaluation_model();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: duplicates, ignored kind, range checks, restart, completion
        set_sentence_count(11'd8);
        queue_request(KIND_START, 10'd0);
        queue_request(KIND_PREMISE, 10'd0);
        queue_request(KIND_PREMISE, 10'd0);
        queue_request(KIND_PREMISE, 10'd1);
        queue_request(KIND_CONCLUSION, 10'd2);
        queue_request(KIND_CONCLUSION, 10'd1);
        queue_request(KIND_UNUSED, 10'd5);
        queue_request(KIND_PREMISE, 10'd8);
        queue_request(KIND_CONCLUSION, 10'd1023);
        queue_request(KIND_START, 10'd1023);
        queue_request(KIND_PREMISE, 10'd7);
        queue_request(KIND_PREMISE, 10'd0);
        queue_request(KIND_CONCLUSION, 10'd3);
        queue_request(KIND_CONCLUSION, 10'd4);
        queue_request(KIND_CONCLUSION, 10'd5);
        queue_request(KIND_PREMISE, 10'd6);
        queue_request(KIND_CONCLUSION, 10'd1);
        queue_request(KIND_CONCLUSION, 10'd2);
        queue_request(KIND_PREMISE, 10'd1023);

        // complete at two, then widen: unseen sentences stay ignored
        set_sentence_count(11'd2);
        queue_request(KIND_START, 10'd512);
        queue_request(KIND_PREMISE, 10'd0);
        queue_request(KIND_CONCLUSION, 10'd1);
        set_sentence_count(11'd8);
        queue_request(KIND_PREMISE, 10'd5);
        queue_request(KIND_CONCLUSION, 10'd7);
        queue_request(KIND_UNUSED, 10'd0);

        // full coverage of all sentences, count above the maximum
        set_sentence_count(11'd2047);
        foreach (perm[i])
            perm[i] = i;
        for (int i = MAX_SENTENCES_DEF - 1; i > 0; i--) begin
            j = $urandom_range(0, i);
            tmp = perm[i];
            perm[i] = perm[j];
            perm[j] = tmp;
        end
        queue_request(KIND_START, 10'd0);
        foreach (perm[i]) begin
            queue_request($urandom_range(0, 1) ? KIND_PREMISE : KIND_CONCLUSION,
                          SENT_W'(perm[i]));
            if ($urandom_range(0, 31) == 0)
                queue_request(KIND_PREMISE, SENT_W'(perm[$urandom_range(0, i)]));
        end
        queue_request(KIND_PREMISE, SENT_W'($urandom_range(0, MAX_SENTENCES_DEF - 1)));
        queue_request(KIND_UNUSED, 10'd1023);
        queue_request(KIND_START, 10'd0);

        phase_counts[0]  = 11'd0;
        phase_counts[1]  = 11'd1;
        phase_counts[2]  = 11'd1024;
        phase_counts[3]  = COUNT_W'($urandom_range(2, 16));
        phase_counts[4]  = COUNT_W'($urandom_range(2, 64));
        phase_counts[5]  = COUNT_W'($urandom_range(17, 200));
        phase_counts[6]  = COUNT_W'($urandom_range(1, 1024));
        phase_counts[7]  = COUNT_W'($urandom_range(2, 8));
        phase_counts[8]  = COUNT_W'($urandom_range(1025, 2047));
        phase_counts[9]  = 11'd3;
        phase_counts[10] = COUNT_W'($urandom_range(2, 32));
        foreach (phase_counts[i]) begin
            set_sentence_count(phase_counts[i]);
            gen_eval_stream(80);
        end

        wait_idle();
        repeat (8) @(posedge i_clk);
        if (error_count == 0 && expected_scores.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
